### rtl/encoder_frame_crc_multiturn_unit_defines.svh
// Assertion macros shared by the encoder frame unit.
// Clocked on aclk, disabled while aresetn is low.
`ifndef ENCODER_FRAME_CRC_MULTITURN_UNIT_DEFINES_SVH
`define ENCODER_FRAME_CRC_MULTITURN_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EFCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/efcm_pkg.sv
// Shared constants and types for the encoder frame unit.
// No dependencies.
package efcm_pkg;

    localparam int POSITION_BITS = 32;
    localparam int POS_OUT_BITS  = 32;
    localparam int POS_EXT_BITS  = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS
                                                                   : POS_OUT_BITS;

    localparam int FRAME_BITS  = 24;
    localparam int ANGLE_BITS  = 14;
    localparam int STATUS_BITS = 4;
    localparam int CRC_BITS    = 6;
    localparam int CRC_IN_BITS = 18;
    localparam int DELTA_BITS  = 15;
    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 72;

    localparam logic [CRC_BITS-1:0] CRC_POLY_RESET = 6'h03;

    localparam logic signed [DELTA_BITS:0] HALF_TURN = 16'sd8192;
    localparam logic signed [DELTA_BITS:0] FULL_TURN = 16'sd16384;

    localparam int PADDR_BITS = 3;
    localparam logic REG_CRC_POLY = 1'b0;

    typedef logic [ANGLE_BITS-1:0]         angle_t;
    typedef logic [STATUS_BITS-1:0]        status_t;
    typedef logic [CRC_BITS-1:0]           crc_t;
    typedef logic signed [DELTA_BITS-1:0]  delta_t;
    typedef logic signed [POSITION_BITS-1:0] pos_t;

endpackage

### rtl/encoder_frame_crc_multiturn_unit.sv
// Encoder frame checker and multi-turn unwrapper, top level.
// Depends on efcm_pkg, efcm_crc6 and encoder_frame_crc_multiturn_unit_defines.svh.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: frame
// m_        out  m_tvalid/m_tready    m_tuser: crc_ok; m_tdata: angle..position
// apb       in   psel/penable/pready  crc_polynomial at address 0
//
// The input transfer loads the input register, which loads the result register, which
// then offers the result on m_. One frame per cycle sustained while m_tready holds.
// Input register, then CRC check, unwrap and saturating add into the result
// register and the unwrap state in the same cycle.
// Stalls on m_ back up through both registers to s_tready.
// Reset: polynomial 3, awaiting first good frame, position zero.
`include "encoder_frame_crc_multiturn_unit_defines.svh"

module encoder_frame_crc_multiturn_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [efcm_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [23:0] frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [efcm_pkg::M_TDATA_BITS-1:0]  m_tdata,  // angle, field_status, delta, position
    output logic                               m_tuser,  // crc_ok
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [efcm_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import efcm_pkg::*;

    crc_t   poly_reg;
    logic   in_valid_reg;
    logic [FRAME_BITS-1:0] frame_reg;

    angle_t prev_angle_reg, prev_angle_next;
    logic   awaiting_reg, awaiting_next;
    pos_t   turn_pos_reg, turn_pos_next;

    logic    out_valid_reg;
    logic    crc_ok_reg;
    angle_t  angle_reg;
    status_t status_reg;
    delta_t  delta_reg, delta_next;

    logic   out_free, work;
    angle_t angle;
    crc_t   crc_calc;
    logic   crc_ok;
    logic signed [DELTA_BITS:0]    diff;
    logic signed [POSITION_BITS:0] sum_wide;
    logic signed [POS_EXT_BITS-1:0] pos_ext;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= CRC_POLY_RESET;
        end else if (psel && penable && pwrite && paddr[PADDR_BITS-1] == REG_CRC_POLY) begin
            poly_reg <= pwdata[CRC_BITS-1:0];
        end
    end
    assign prdata = (paddr[PADDR_BITS-1] == REG_CRC_POLY) ? {26'd0, poly_reg} : 32'd0;

    // flow control
    assign out_free = !out_valid_reg || m_tready;
    assign work     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            frame_reg <= s_tdata[FRAME_BITS-1:0];
        end
    end

    efcm_crc6 u_crc (
        .data_in (frame_reg[FRAME_BITS-1:CRC_BITS]),
        .poly    (poly_reg),
        .crc     (crc_calc)
    );

    assign angle  = frame_reg[FRAME_BITS-1:FRAME_BITS-ANGLE_BITS];
    assign crc_ok = (crc_calc == frame_reg[CRC_BITS-1:0]);

    always_comb begin
        diff = $signed({2'b00, angle}) - $signed({2'b00, prev_angle_reg});
        if (diff > HALF_TURN) begin
            diff = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
            diff = diff + FULL_TURN;
        end

        prev_angle_next = prev_angle_reg;
        awaiting_next   = awaiting_reg;
        turn_pos_next   = turn_pos_reg;
        delta_next      = '0;

        if (crc_ok) begin
            prev_angle_next = angle;
            awaiting_next   = 1'b0;
            if (!awaiting_reg) begin
                delta_next = diff[DELTA_BITS-1:0];
            end
        end

        sum_wide = $signed({turn_pos_reg[POSITION_BITS-1], turn_pos_reg})
                 + (POSITION_BITS+1)'(delta_next);
        if (crc_ok) begin
            if (sum_wide[POSITION_BITS] != sum_wide[POSITION_BITS-1]) begin
                turn_pos_next = sum_wide[POSITION_BITS]
                              ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                              : {1'b0, {(POSITION_BITS-1){1'b1}}};
            end else begin
                turn_pos_next = sum_wide[POSITION_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            awaiting_reg   <= 1'b1;
            turn_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (work) begin
                prev_angle_reg <= prev_angle_next;
                awaiting_reg   <= awaiting_next;
                turn_pos_reg   <= turn_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            crc_ok_reg <= crc_ok;
            angle_reg  <= angle;
            status_reg <= frame_reg[CRC_BITS+STATUS_BITS-1:CRC_BITS];
            delta_reg  <= delta_next;
        end
    end

    // position register follows the state, so it is taken from the state
    assign pos_ext  = POS_EXT_BITS'(turn_pos_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = crc_ok_reg;
    assign m_tdata  = {7'd0, pos_ext[POS_OUT_BITS-1:0], delta_reg, status_reg, angle_reg};

    `EFCM_ASSERT_IMP(a_reject_zero_delta, m_tvalid && !m_tuser, delta_reg == '0,
        "rejected frame carries nonzero delta")
    `EFCM_ASSERT_IMP(a_delta_range, m_tvalid,
        (delta_reg <= 15'sd8192) && (delta_reg >= -15'sd8192),
        "delta outside half turn")
    `EFCM_ASSERT_IMP(a_first_clean, awaiting_reg,
        (turn_pos_reg == '0) && (prev_angle_reg == '0),
        "state moved before first good frame")
    `EFCM_ASSERT_NXT(a_hold_state, !work, $stable(turn_pos_reg) && $stable(awaiting_reg),
        "unwrap state changed without a frame")

endmodule

### rtl/efcm_crc6.sv
// CRC-6 over 18 bits, MSB first, zero start, programmable polynomial.
// Depends on efcm_pkg.
module efcm_crc6 (
    input  logic [efcm_pkg::CRC_IN_BITS-1:0] data_in,
    input  efcm_pkg::crc_t                   poly,
    output efcm_pkg::crc_t                   crc
);
    import efcm_pkg::*;

    always_comb begin
        crc_t c;
        logic fb;
        c = '0;
        for (int i = CRC_IN_BITS - 1; i >= 0; i--) begin
            fb = c[CRC_BITS-1] ^ data_in[i];
            c  = {c[CRC_BITS-2:0], 1'b0} ^ (fb ? poly : '0);
        end
        crc = c;
    end

endmodule
